>>> hdl/psdci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psdci_pkg
// Shared types, widths and register codes of the charge integrator.
// ----------------------------------------------------------------------------
package psdci_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int IDX_W       = 13;
  localparam int SAMPLE_W    = 14;
  localparam int GATE_W      = 12;
  localparam int WIN_MAX     = 64;
  localparam int WIN_W       = 7;
  localparam int BL_SUM_W    = 20;
  localparam int SUM_W       = 26;
  localparam int CNT_W       = 13;
  localparam int BASE_W      = 22;
  localparam int Q_W         = 36;
  localparam int FRAC_W      = 8;
  localparam int DIV_W       = BL_SUM_W + FRAC_W;
  localparam int PROD_W      = CNT_W + BASE_W;
  localparam int ACC_W       = Q_W + 2;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_PRE_TRIGGER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_GATE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_GATE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BL_SOURCE    = 3'd5;

  localparam logic signed [ACC_W-1:0] Q_HI = (ACC_W'(1) <<< (Q_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Q_LO = -(ACC_W'(1) <<< (Q_W - 1));

  typedef struct packed {
    logic [GATE_W-1:0] pre_trigger;
    logic [GATE_W-1:0] pre_gate;
    logic [GATE_W-1:0] short_gate;
    logic [GATE_W-1:0] long_gate;
    logic [IDX_W-1:0]  sample_count;
    logic              bl_source;
  } cfg_t;

  typedef struct packed {
    logic [BL_SUM_W-1:0] bl_sum;
    logic [SUM_W-1:0]    sh_sum;
    logic [CNT_W-1:0]    sh_cnt;
    logic [SUM_W-1:0]    tl_sum;
    logic [CNT_W-1:0]    tl_cnt;
    logic [WIN_W-1:0]    win;
    logic                bl_source;
    logic [SAMPLE_W-1:0] board;
  } wf_t;

  function automatic logic [Q_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > Q_HI) r = Q_HI;
    if (v < Q_LO) r = Q_LO;
    return r[Q_W-1:0];
  endfunction

endpackage

>>> hdl/psdci_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psdci_front
// Sample classifier: baseline, short and tail accumulation per waveform.
// ----------------------------------------------------------------------------
module psdci_front import psdci_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic [SAMPLE_W-1:0] in_board_baseline,
  input  logic                in_last,
  input  logic                q_full,
  output logic                q_push,
  output wf_t                 q_entry
);

  logic [IDX_W-1:0]    idx_r;
  logic [BL_SUM_W-1:0] bl_sum_r, bl_sum_nxt;
  logic [SUM_W-1:0]    sh_sum_r, sh_sum_nxt, tl_sum_r, tl_sum_nxt;
  logic [CNT_W-1:0]    sh_cnt_r, sh_cnt_nxt, tl_cnt_r, tl_cnt_nxt;

  logic                accept;
  logic [IDX_W-1:0]    n_use;
  logic signed [13:0]  g_s, s_end, l_end, i_s;
  logic                in_range;

  assign in_stall = q_full & in_last;
  assign accept   = in_valid & ~in_stall;
  assign q_push   = accept & in_last;

  assign n_use = (cfg.sample_count > IDX_W'(MAX_SAMPLES)) ? IDX_W'(MAX_SAMPLES)
                                                          : cfg.sample_count;
  assign g_s   = $signed({2'b00, cfg.pre_trigger}) - $signed({2'b00, cfg.pre_gate});
  assign s_end = g_s + $signed({2'b00, cfg.short_gate});
  assign l_end = g_s + $signed({2'b00, cfg.long_gate});
  assign i_s   = $signed({1'b0, idx_r});
  assign in_range = idx_r < n_use;

  always_comb begin
    bl_sum_nxt = bl_sum_r;
    sh_sum_nxt = sh_sum_r;
    sh_cnt_nxt = sh_cnt_r;
    tl_sum_nxt = tl_sum_r;
    tl_cnt_nxt = tl_cnt_r;
    if (in_range) begin
      if (i_s < g_s && idx_r < IDX_W'(WIN_MAX)) begin
        bl_sum_nxt = bl_sum_r + BL_SUM_W'(in_sample);
      end
      if (i_s > g_s && i_s <= s_end) begin
        sh_sum_nxt = sh_sum_r + SUM_W'(in_sample);
        sh_cnt_nxt = sh_cnt_r + CNT_W'(1);
      end else if (i_s > s_end && i_s <= l_end) begin
        tl_sum_nxt = tl_sum_r + SUM_W'(in_sample);
        tl_cnt_nxt = tl_cnt_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    q_entry.bl_sum    = bl_sum_nxt;
    q_entry.sh_sum    = sh_sum_nxt;
    q_entry.sh_cnt    = sh_cnt_nxt;
    q_entry.tl_sum    = tl_sum_nxt;
    q_entry.tl_cnt    = tl_cnt_nxt;
    q_entry.bl_source = cfg.bl_source;
    q_entry.board     = in_board_baseline;
    if (g_s <= 14'sd0) begin
      q_entry.win = '0;
    end else if (g_s > 14'(WIN_MAX)) begin
      q_entry.win = WIN_W'(WIN_MAX);
    end else begin
      q_entry.win = g_s[WIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      bl_sum_r <= '0;
      sh_sum_r <= '0;
      sh_cnt_r <= '0;
      tl_sum_r <= '0;
      tl_cnt_r <= '0;
    end else if (accept) begin
      if (in_last) begin
        idx_r    <= '0;
        bl_sum_r <= '0;
        sh_sum_r <= '0;
        sh_cnt_r <= '0;
        tl_sum_r <= '0;
        tl_cnt_r <= '0;
      end else begin
        if (idx_r < IDX_W'(MAX_SAMPLES)) idx_r <= idx_r + IDX_W'(1);
        bl_sum_r <= bl_sum_nxt;
        sh_sum_r <= sh_sum_nxt;
        sh_cnt_r <= sh_cnt_nxt;
        tl_sum_r <= tl_sum_nxt;
        tl_cnt_r <= tl_cnt_nxt;
      end
    end
  end

endmodule

>>> hdl/psdci_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psdci_queue
// Two-entry queue of finished waveform sums between front and back.
// ----------------------------------------------------------------------------
module psdci_queue import psdci_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  wf_t  push_entry,
  input  logic pop,
  output wf_t  pop_entry,
  output logic valid,
  output logic full
);

  wf_t        mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign valid     = count_r != 2'd0;
  assign full      = count_r == 2'd2;
  assign do_push   = push & ~full;
  assign do_pop    = pop & valid;
  assign pop_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hdl/psdci_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psdci_back
// Per-waveform baseline division, charge products and output register.
// ----------------------------------------------------------------------------
module psdci_back import psdci_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  wf_t               q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [Q_W-1:0]    out_charge_short,
  output logic [Q_W-1:0]    out_charge_long,
  output logic [BASE_W-1:0] out_baseline_value,
  output logic              out_window_error
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]              state_r;
  logic [4:0]              cnt_r;
  wf_t                     ent_r;
  logic [BASE_W-1:0]       b_r;
  logic                    err_r;
  logic [WIN_W-1:0]        rem_r, rem_nxt;
  logic [DIV_W-1:0]        quo_r, quo_nxt;
  logic [WIN_W:0]          shifted;
  logic [PROD_W-1:0]       ps_r, pt_r;
  logic signed [ACC_W-1:0] qs_r, qt_r, ql;
  logic                    out_free;

  assign out_free = ~out_valid | ~out_stall;
  assign q_pop    = (state_r == ST_IDLE) & q_valid;
  assign ql       = qs_r + qt_r;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    if (shifted >= {1'b0, ent_r.win}) begin
      rem_nxt = WIN_W'(shifted - {1'b0, ent_r.win});
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[WIN_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state_r == ST_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_entry.bl_source && q_entry.win != '0) state_r <= ST_DIV;
            else state_r <= ST_MUL;
          end
        end
        ST_DIV: begin
          if (cnt_r == 5'd0) state_r <= ST_MUL;
        end
        ST_MUL: state_r <= ST_SUM;
        ST_SUM: state_r <= ST_OUT;
        ST_OUT: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ent_r <= q_entry;
        rem_r <= '0;
        quo_r <= {q_entry.bl_sum, FRAC_W'(0)};
        cnt_r <= 5'(DIV_W - 1);
        err_r <= q_entry.bl_source && q_entry.win == '0;
        if (q_entry.bl_source) b_r <= '0;
        else b_r <= {q_entry.board, FRAC_W'(0)};
      end
      ST_DIV: begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) b_r <= quo_nxt[BASE_W-1:0];
      end
      ST_MUL: begin
        ps_r <= {{BASE_W{1'b0}}, ent_r.sh_cnt} * {{CNT_W{1'b0}}, b_r};
        pt_r <= {{BASE_W{1'b0}}, ent_r.tl_cnt} * {{CNT_W{1'b0}}, b_r};
      end
      ST_SUM: begin
        qs_r <= $signed({3'b000, ps_r}) - $signed({4'b0000, ent_r.sh_sum, FRAC_W'(0)});
        qt_r <= $signed({3'b000, pt_r}) - $signed({4'b0000, ent_r.tl_sum, FRAC_W'(0)});
      end
      ST_OUT: begin
        if (out_free) begin
          out_charge_short   <= sat_q(qs_r);
          out_charge_long    <= sat_q(ql);
          out_baseline_value <= b_r;
          out_window_error   <= err_r;
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

endmodule

>>> hdl/psd_charge_integrator_unit.sv
`timescale 1ns / 1ps
// The back end runs the 28-step baseline divider for an averaged baseline, skips it
// with the board baseline or an empty window, then forms products and sums and
// registers the result; it pops a new waveform only when idle again. Throughput: one
// sample per cycle, but the last sample of a waveform stalls while the queue is full.
// Two finished waveforms can queue before the front stalls.
// Reset: synchronous, active low; registers return to defaults, sums clear.
// ----------------------------------------------------------------------------
// psd_charge_integrator_unit
// Pulse shape discrimination charge integrator, top level.
// ----------------------------------------------------------------------------
module psd_charge_integrator_unit import psdci_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic [SAMPLE_W-1:0]   in_board_baseline,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [Q_W-1:0]        out_charge_short,
  output logic [Q_W-1:0]        out_charge_long,
  output logic [BASE_W-1:0]     out_baseline_value,
  output logic                  out_window_error
);

  cfg_t cfg_r;
  logic q_push, q_pop, q_valid, q_full;
  wf_t  push_entry, pop_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre_trigger  <= '0;
      cfg_r.pre_gate     <= '0;
      cfg_r.short_gate   <= '0;
      cfg_r.long_gate    <= '0;
      cfg_r.sample_count <= IDX_W'(MAX_SAMPLES);
      cfg_r.bl_source    <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PRE_TRIGGER:  cfg_r.pre_trigger  <= cfg_data[GATE_W-1:0];
        CFG_PRE_GATE:     cfg_r.pre_gate     <= cfg_data[GATE_W-1:0];
        CFG_SHORT_GATE:   cfg_r.short_gate   <= cfg_data[GATE_W-1:0];
        CFG_LONG_GATE:    cfg_r.long_gate    <= cfg_data[GATE_W-1:0];
        CFG_SAMPLE_COUNT: cfg_r.sample_count <= cfg_data[IDX_W-1:0];
        CFG_BL_SOURCE:    cfg_r.bl_source    <= cfg_data[0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  psdci_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .in_board_baseline (in_board_baseline),
    .in_last           (in_last),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (push_entry)
  );

  psdci_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .valid      (q_valid),
    .full       (q_full)
  );

  psdci_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_entry            (pop_entry),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_charge_short   (out_charge_short),
    .out_charge_long    (out_charge_long),
    .out_baseline_value (out_baseline_value),
    .out_window_error   (out_window_error)
  );

endmodule

>>> tb/sv/psd_charge_integrator_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_charge_integrator_unit_checker
// Watches the register port and both streams of the charge integrator. It
// mirrors the registers, integrates every accepted sample into its own
// baseline and gate sums, and queues one charge result per finished waveform.
// Each result taken from the block is compared field by field, in order.
// ----------------------------------------------------------------------------
module psd_charge_integrator_unit_checker import psdci_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic [SAMPLE_W-1:0]   in_board_baseline,
  input  logic                  in_last,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [Q_W-1:0]        out_charge_short,
  input  logic [Q_W-1:0]        out_charge_long,
  input  logic [BASE_W-1:0]     out_baseline_value,
  input  logic                  out_window_error,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  localparam longint CHARGE_TOP = (longint'(1) << (Q_W - 1)) - 1;
  localparam longint CHARGE_BOT = -(longint'(1) << (Q_W - 1));
  localparam longint BASE_TOP   = (longint'(1) << BASE_W) - 1;

  typedef struct packed {
    logic [Q_W-1:0]    charge_short;
    logic [Q_W-1:0]    charge_long;
    logic [BASE_W-1:0] baseline;
    logic              win_err;
  } charge_rec_t;

  logic [GATE_W-1:0]   pre_trigger_r;
  logic [GATE_W-1:0]   pre_gate_r;
  logic [GATE_W-1:0]   short_gate_r;
  logic [GATE_W-1:0]   long_gate_r;
  logic [IDX_W-1:0]    sample_count_r;
  logic                bl_source_r;

  logic [IDX_W-1:0]    wave_idx;
  logic [BL_SUM_W-1:0] bl_acc;
  logic [SUM_W-1:0]    short_acc;
  logic [CNT_W-1:0]    short_n;
  logic [SUM_W-1:0]    tail_acc;
  logic [CNT_W-1:0]    tail_n;

  charge_rec_t         expected_charges[$];
  charge_rec_t         head;

  function automatic longint clamp_charge(input longint v);
    if (v > CHARGE_TOP) return CHARGE_TOP;
    if (v < CHARGE_BOT) return CHARGE_BOT;
    return v;
  endfunction

  task automatic clear_sums();
    wave_idx  = '0;
    bl_acc    = '0;
    short_acc = '0;
    short_n   = '0;
    tail_acc  = '0;
    tail_n    = '0;
  endtask

  task automatic integrate_sample(input logic [SAMPLE_W-1:0] s,
                                  input logic [SAMPLE_W-1:0] board,
                                  input logic last);
    int          g;
    int          w;
    int          n;
    int          i;
    int          s_end;
    int          l_end;
    longint      b;
    longint      qs;
    longint      ql;
    charge_rec_t r;
    g     = int'(pre_trigger_r) - int'(pre_gate_r);
    w     = (g > WIN_MAX) ? WIN_MAX : g;
    n     = (int'(sample_count_r) > MAX_SAMPLES) ? MAX_SAMPLES : int'(sample_count_r);
    i     = int'(wave_idx);
    s_end = g + int'(short_gate_r);
    l_end = g + int'(long_gate_r);
    if (i < n) begin
      if (i < w) bl_acc = bl_acc + s;
      if (i > g && i <= s_end) begin
        short_acc = short_acc + s;
        short_n   = short_n + 1'b1;
      end else if (i > s_end && i <= l_end) begin
        tail_acc = tail_acc + s;
        tail_n   = tail_n + 1'b1;
      end
    end
    if (wave_idx < MAX_SAMPLES) wave_idx = wave_idx + 1'b1;
    if (last) begin
      r.win_err = 1'b0;
      if (!bl_source_r) begin
        b = longint'(board) << FRAC_W;
      end else if (w <= 0) begin
        b         = 0;
        r.win_err = 1'b1;
      end else begin
        b = (longint'(bl_acc) << FRAC_W) / w;
      end
      if (b > BASE_TOP) b = BASE_TOP;
      qs = longint'(short_n) * b - (longint'(short_acc) << FRAC_W);
      ql = clamp_charge(qs + longint'(tail_n) * b - (longint'(tail_acc) << FRAC_W));
      qs = clamp_charge(qs);
      r.charge_short = qs[Q_W-1:0];
      r.charge_long  = ql[Q_W-1:0];
      r.baseline     = b[BASE_W-1:0];
      expected_charges.push_back(r);
      clear_sums();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pre_trigger_r  = '0;
      pre_gate_r     = '0;
      short_gate_r   = '0;
      long_gate_r    = '0;
      sample_count_r = IDX_W'(MAX_SAMPLES);
      bl_source_r    = 1'b1;
      clear_sums();
      expected_charges.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PRE_TRIGGER: begin
            pre_trigger_r = cfg_data[GATE_W-1:0];
          end
          CFG_PRE_GATE: begin
            pre_gate_r = cfg_data[GATE_W-1:0];
          end
          CFG_SHORT_GATE: begin
            short_gate_r = cfg_data[GATE_W-1:0];
          end
          CFG_LONG_GATE: begin
            long_gate_r = cfg_data[GATE_W-1:0];
          end
          CFG_SAMPLE_COUNT: begin
            sample_count_r = cfg_data[IDX_W-1:0];
          end
          CFG_BL_SOURCE: begin
            bl_source_r = cfg_data[0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) integrate_sample(in_sample, in_board_baseline, in_last);
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_charges.size() == 0) begin
          $error("unexpected result: charge_short %0d, charge_long %0d, baseline %0d",
                 $signed(out_charge_short), $signed(out_charge_long), out_baseline_value);
          fail_count++;
        end else begin
          head = expected_charges.pop_front();
          if (out_charge_short !== head.charge_short) begin
            $error("charge_short: expected %0d, got %0d",
                   $signed(head.charge_short), $signed(out_charge_short));
            fail_count++;
          end
          if (out_charge_long !== head.charge_long) begin
            $error("charge_long: expected %0d, got %0d",
                   $signed(head.charge_long), $signed(out_charge_long));
            fail_count++;
          end
          if (out_baseline_value !== head.baseline) begin
            $error("baseline_value: expected %0d, got %0d",
                   head.baseline, out_baseline_value);
            fail_count++;
          end
          if (out_window_error !== head.win_err) begin
            $error("window_error: expected %0d, got %0d",
                   head.win_err, out_window_error);
            fail_count++;
          end
        end
      end
    end
    pending = expected_charges.size();
  end

endmodule

>>> tb/sv/psd_charge_integrator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_charge_integrator_unit_test
// Drives digitizer waveforms into the charge integrator under a range of gate,
// window and baseline settings, with random stalls on both streams, a long
// output hold-off and a sample count beyond the maximum. A checker beside the
// block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module psd_charge_integrator_unit_test;
  import psdci_pkg::*;

  localparam int DRAIN_CYCLES = 48;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst_n             = 1'b0;
  logic                  cfg_wr_en         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = '0;
  logic [CFG_DATA_W-1:0] cfg_data          = '0;
  logic                  in_valid          = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_sample         = '0;
  logic [SAMPLE_W-1:0]   in_board_baseline = '0;
  logic                  in_last           = 1'b0;
  logic                  out_valid;
  logic                  out_stall         = 1'b0;
  logic [Q_W-1:0]        out_charge_short;
  logic [Q_W-1:0]        out_charge_long;
  logic [BASE_W-1:0]     out_baseline_value;
  logic                  out_window_error;

  int chk_fail;
  int chk_pending;
  int chk_checked;

  int tx_idle_pct   = 6;
  int rx_idle_pct   = 82;
  int hold_reqs     = 0;
  int hold_done     = 0;
  int hold_left     = 0;
  int cycle_cnt     = 0;
  int samples_sent  = 0;
  int waves_sent    = 0;
  int settings_used = 0;

  cfg_t cur_cfg;

  psd_charge_integrator_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_board_baseline  (in_board_baseline),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_charge_short   (out_charge_short),
    .out_charge_long    (out_charge_long),
    .out_baseline_value (out_baseline_value),
    .out_window_error   (out_window_error)
  );

  psd_charge_integrator_unit_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_board_baseline  (in_board_baseline),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_charge_short   (out_charge_short),
    .out_charge_long    (out_charge_long),
    .out_baseline_value (out_baseline_value),
    .out_window_error   (out_window_error),
    .fail_count         (chk_fail),
    .pending            (chk_pending),
    .checked            (chk_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // hold off the result stream on request, otherwise stall at random
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_reqs != hold_done) begin
      hold_done++;
      hold_left = HOLD_CYCLES - 1;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic cfg_t settings(input int pt, input int pg, input int sg, input int lg,
                                    input int sc, input bit src);
    cfg_t c;
    c.pre_trigger  = GATE_W'(pt);
    c.pre_gate     = GATE_W'(pg);
    c.short_gate   = GATE_W'(sg);
    c.long_gate    = GATE_W'(lg);
    c.sample_count = IDX_W'(sc);
    c.bl_source    = src;
    return c;
  endfunction

  function automatic cfg_t random_settings();
    int pt;
    int pg;
    int sg;
    int lg;
    int sc;
    int r;
    pt = ($urandom_range(4) == 0) ? $urandom_range(41, 90) : $urandom_range(0, 40);
    pg = ($urandom_range(3) == 0) ? $urandom_range(pt, pt + 10) : $urandom_range(0, pt);
    sg = $urandom_range(0, 24);
    lg = $urandom_range(0, 40);
    if ($urandom_range(9) == 0) begin
      sg = 4095;
      lg = $urandom_range(1) ? 4095 : lg;
    end
    r = $urandom_range(99);
    if (r < 50) sc = MAX_SAMPLES;
    else if (r < 75) sc = $urandom_range(1, 60);
    else if (r < 85) sc = 0;
    else sc = $urandom_range(MAX_SAMPLES + 1, 8191);
    return settings(pt, pg, sg, lg, sc, $urandom_range(99) < 65);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(19))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom_range(0, 16383));
    endcase
  endfunction

  task automatic wait_idle();
    while (chk_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic apply_settings(input cfg_t c);
    wait_idle();
    write_reg(CFG_PRE_TRIGGER,  {1'($urandom), c.pre_trigger});
    write_reg(CFG_PRE_GATE,     {1'($urandom), c.pre_gate});
    write_reg(CFG_SHORT_GATE,   {1'($urandom), c.short_gate});
    write_reg(CFG_LONG_GATE,    {1'($urandom), c.long_gate});
    write_reg(CFG_SAMPLE_COUNT, c.sample_count);
    write_reg(CFG_BL_SOURCE,    {12'($urandom), c.bl_source});
    cur_cfg = c;
    settings_used++;
  endtask

  task automatic push_item(input logic [SAMPLE_W-1:0] s, input logic [SAMPLE_W-1:0] b,
                           input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_sample         = s;
    in_board_baseline = b;
    in_last           = last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    samples_sent++;
    if (last) waves_sent++;
  endtask

  task automatic send_waveform(input int len, input bit terminate);
    logic [SAMPLE_W-1:0] board_lvl;
    board_lvl = pick_sample();
    for (int k = 0; k < len; k++) begin
      push_item(pick_sample(),
                ($urandom_range(7) == 0) ? pick_sample() : board_lvl,
                terminate && (k == len - 1));
    end
  endtask

  function automatic int pick_length();
    int reach;
    int r;
    reach = int'(cur_cfg.pre_trigger) - int'(cur_cfg.pre_gate) + 2 +
            ((cur_cfg.long_gate > cur_cfg.short_gate) ? int'(cur_cfg.long_gate)
                                                      : int'(cur_cfg.short_gate));
    if (reach < 4) reach = 4;
    if (reach > 64) reach = 64;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(reach, reach + 8);
    if (r < 85) return $urandom_range(1, reach);
    return $urandom_range(1, 3);
  endfunction

  initial begin
    int phase_start;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty averaging window straight after reset
    cur_cfg = settings(0, 0, 0, 0, MAX_SAMPLES, 1'b1);
    push_item('0, '0, 1'b0);
    push_item('1, '1, 1'b0);
    push_item('0, '0, 1'b1);
    waves_sent = waves_sent;

    // averaging, long gate shorter than short gate
    apply_settings(settings(10, 2, 4, 2, MAX_SAMPLES, 1'b1));
    write_reg(CFG_SPARE_LO, '1);
    for (int k = 0; k < 10; k++) push_item(k[0] ? '0 : '1, SAMPLE_W'(5), k == 9);

    // board baseline with a negative gate start
    apply_settings(settings(2, 6, 6, 10, MAX_SAMPLES, 1'b0));
    for (int k = 0; k < 6; k++) push_item(pick_sample(), (k == 5) ? '1 : pick_sample(), k == 5);

    // one sample in use, short waveform
    apply_settings(settings(20, 0, 3, 5, 1, 1'b1));
    for (int k = 0; k < 3; k++) push_item(pick_sample(), pick_sample(), k == 2);

    // every sample ignored, extreme gate registers
    apply_settings(settings(4095, 4095, 4095, 4095, 0, 1'b1));
    write_reg(CFG_SPARE_HI, '0);
    push_item('1, '1, 1'b0);
    push_item('1, '0, 1'b1);

    // reconfigure in the middle of a waveform
    apply_settings(settings(3, 0, 2, 6, MAX_SAMPLES, 1'b1));
    for (int k = 0; k < 3; k++) push_item(pick_sample(), pick_sample(), 1'b0);
    apply_settings(settings(5, 1, 3, 8, MAX_SAMPLES, 1'b0));
    for (int k = 0; k < 3; k++) push_item(pick_sample(), pick_sample(), k == 2);

    // sample count beyond the maximum, gates running past the end
    apply_settings(settings(20, 0, 4095, 4095, 8191, 1'b1));
    send_waveform(40, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case (p / (PHASES / 3))
        0: begin
          tx_idle_pct = 6;
          rx_idle_pct = 82;
        end
        1: begin
          tx_idle_pct = 82;
          rx_idle_pct = 6;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      apply_settings(random_settings());
      if ($urandom_range(3) == 0) write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                                            CFG_DATA_W'($urandom));
      if (p == PHASES - 3) begin
        hold_reqs++;
        repeat (8) send_waveform($urandom_range(1, 3), 1'b1);
      end
      phase_start = samples_sent;
      while (samples_sent - phase_start < PHASE_ITEMS) send_waveform(pick_length(), 1'b1);
      if ($urandom_range(3) == 0) send_waveform($urandom_range(1, 5), 1'b0);
    end

    wait_idle();
    $display("Checked %0d charge results from %0d waveforms, %0d samples in all,",
             chk_checked, waves_sent, samples_sent);
    $display("under %0d register settings, with stalls on both sides and a long hold-off",
             settings_used);
    if (chk_fail == 0 && chk_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
